@@ rtl/core/ptb_pkg.sv @@
package ptb_pkg;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int ID_W     = 4;
  localparam int CMD_W    = 2;
  localparam int WORD_W   = PERIOD_W + TIME_W;

  // command field codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // classified operations handed from front to back
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic STAT_OK          = 1'b0;
  localparam logic STAT_NOT_RUNNING = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] period_ms;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic            status;
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          op;
    logic                in_range;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] period_ms;
    logic [TIME_W-1:0]   now_ms;
  } ptb_cmd_t;

endpackage

@@ rtl/core/ptb_ram.sv @@
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ptb_front.sv @@
module ptb_front import ptb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_pop,
  output ptb_cmd_t q_cmd
);

  localparam int QDEPTH = 2;

  ptb_cmd_t   q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       in_range;
  ptb_cmd_t   cls;

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_ptr_r];

  assign in_range = (9'(in_item.timer_id) < 9'(NUM_TIMERS));

  // a start of an absent slot does nothing, so it becomes a no-op here
  always_comb begin
    cls.in_range  = in_range;
    cls.timer_id  = in_item.timer_id;
    cls.period_ms = in_item.period_ms;
    cls.now_ms    = in_item.now_ms;
    case (in_item.cmd)
      CMD_TICK:  cls.op = OP_TICK;
      CMD_START: cls.op = in_range ? OP_START : OP_NOP;
      CMD_STOP:  cls.op = OP_STOP;
      default:   cls.op = OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/core/ptb_back.sv @@
module ptb_back import ptb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_pop,
  input  ptb_cmd_t  q_cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     pend_r, pend_nxt;
  logic                  have_pend_r, have_pend_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [NUM_TIMERS-1:0] running_r, running_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  out_free;
  logic [SLOT_W-1:0]     q_slot;
  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;
  logic [PERIOD_W-1:0]   rd_period;
  logic [TIME_W-1:0]     rd_deadline, diff, new_deadline, start_deadline;
  logic                  expired;
  out_item_t             ok_item, pend_item;

  ptb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_period      = ram_rdata[WORD_W-1:TIME_W];
  assign rd_deadline    = ram_rdata[TIME_W-1:0];
  // wrap-aware now >= deadline
  assign diff           = now_r - rd_deadline;
  assign expired        = running_r[idx_r] && !diff[TIME_W-1];
  assign new_deadline   = rd_deadline + TIME_W'(rd_period);
  assign start_deadline = q_cmd.now_ms + TIME_W'(q_cmd.period_ms);
  assign q_slot         = SLOT_W'(q_cmd.timer_id);
  assign out_free       = !out_valid_r || !out_stall;

  always_comb begin
    ok_item          = '0;
    ok_item.status   = STAT_OK;
    ok_item.last     = 1'b1;
    pend_item        = '0;
    pend_item.status = STAT_OK;
    pend_item.fired  = 1'b1;
    pend_item.fired_id = ID_W'(pend_r);
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    now_nxt       = now_r;
    running_nxt   = running_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {rd_period, new_deadline};

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_TICK: begin
              q_pop         = 1'b1;
              now_nxt       = q_cmd.now_ms;
              idx_nxt       = '0;
              have_pend_nxt = 1'b0;
              state_nxt     = ST_RD;
            end
            OP_START: begin
              if (out_free) begin
                q_pop               = 1'b1;
                running_nxt[q_slot] = 1'b1;
                ram_we              = 1'b1;
                ram_waddr           = q_slot;
                ram_wdata           = {q_cmd.period_ms, start_deadline};
                out_valid_nxt       = 1'b1;
                out_item_nxt        = ok_item;
              end
            end
            OP_STOP: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt  = ok_item;
                if (q_cmd.in_range && running_r[q_slot]) begin
                  running_nxt[q_slot] = 1'b0;
                end else begin
                  out_item_nxt.status = STAT_NOT_RUNNING;
                end
              end
            end
            default: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt  = ok_item;
              end
            end
          endcase
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_EV;
      end
      ST_EV: begin
        // one fired id is held back so the final one can carry last
        if (!expired || !have_pend_r || out_free) begin
          if (expired) begin
            ram_we        = 1'b1;
            pend_nxt      = idx_r;
            have_pend_nxt = 1'b1;
            if (have_pend_r) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = pend_item;
            end
          end
          if (idx_r == LAST_SLOT) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt   = idx_r + SLOT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = ok_item;
          if (have_pend_r) begin
            out_item_nxt      = pend_item;
            out_item_nxt.last = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_pend_r <= 1'b0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_pend_r <= have_pend_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_r     <= pend_nxt;
    now_r      <= now_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/periodic_timer_bank.sv @@
// start, stop and unused commands: queued, then the result is registered at the output
// tick: each timer slot is read and then checked in turn, then a final beat is sent;
//   the registered read of the timer memory sets this pace
// a two-beat queue in front keeps accepting, until it is full, while the scan runs
// reset clears the running flags, the queue and the output register;
//   the period and deadline memory is not cleared and is written by start and by ticks that fire
module periodic_timer_bank import ptb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     q_valid;
  logic     q_pop;
  ptb_cmd_t q_cmd;

  ptb_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  ptb_back #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.fired |-> out_item.last)
    else $error("non-fired beat without last");

  a_status_not_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == STAT_NOT_RUNNING) |-> !out_item.fired)
    else $error("fired beat with error status");

  a_fired_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fired |-> (9'(out_item.fired_id) < 9'(NUM_TIMERS)))
    else $error("fired id outside the bank");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptb_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_TOP   = '1;
  localparam logic [TIME_W-1:0] TIME_HALF  = TIME_W'(1) << (TIME_W - 1);

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // when set, neither side idles
  bit calm = 1'b0;
  int mismatches = 0;

  // predicted state of the bank
  logic                timer_running  [SLOTS];
  logic [PERIOD_W-1:0] timer_period   [SLOTS];
  logic [TIME_W-1:0]   timer_deadline [SLOTS];
  out_item_t           pending_results [$];

  always #4 clk = ~clk;

  periodic_timer_bank #(.NUM_TIMERS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // works out the results of one accepted command and updates the timer state
  function automatic void predict_command(in_item_t it);
    out_item_t         batch [SLOTS];
    out_item_t         r;
    logic [TIME_W-1:0] lag;
    int                n;
    n = 0;
    r = '0;
    r.status = STAT_OK;
    r.last = 1'b1;
    case (it.cmd)
      CMD_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          // wrap-aware now >= deadline
          lag = it.now_ms - timer_deadline[s];
          if (timer_running[s] && !lag[TIME_W-1]) begin
            timer_deadline[s] = timer_deadline[s] + TIME_W'(timer_period[s]);
            batch[n] = '0;
            batch[n].status = STAT_OK;
            batch[n].fired = 1'b1;
            batch[n].fired_id = ID_W'(s);
            n++;
          end
        end
      end
      CMD_START: begin
        timer_running[it.timer_id] = 1'b1;
        timer_period[it.timer_id] = it.period_ms;
        timer_deadline[it.timer_id] = it.now_ms + TIME_W'(it.period_ms);
      end
      CMD_STOP: begin
        r.status = timer_running[it.timer_id] ? STAT_OK : STAT_NOT_RUNNING;
        timer_running[it.timer_id] = 1'b0;
      end
      default: begin
      end
    endcase
    if (n == 0) begin
      pending_results.push_back(r);
    end else begin
      batch[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) pending_results.push_back(batch[k]);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with nothing pending", int'(got), 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.fired !== want.fired) report_mismatch("fired", got.fired, want.fired);
    if (got.fired_id !== want.fired_id) report_mismatch("fired_id", got.fired_id, want.fired_id);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
    out_stall <= !calm && ($urandom_range(99) < 9);
  end

  // valid stays high on return so back-to-back beats need no second assignment
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [PERIOD_W-1:0] period, input logic [TIME_W-1:0] now);
    in_item_t it;
    it.cmd = cmd;
    it.timer_id = id;
    it.period_ms = period;
    it.now_ms = now;
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_quiet_bank();
    send_item(CMD_TICK, 4'd0, 32'd0, '0);
    send_item(CMD_UNUSED, '1, '1, TIME_TOP);
    send_item(CMD_STOP, 4'd7, 32'd0, 48'd50);
    settle();
  endtask

  task automatic test_start_stop();
    send_item(CMD_START, 4'd3, 32'd5, 48'd100);
    send_item(CMD_START, 4'd3, 32'hffff_ffff, 48'd100);
    send_item(CMD_STOP, 4'd3, 32'd0, 48'd101);
    send_item(CMD_STOP, 4'd3, 32'd0, 48'd102);
    settle();
  endtask

  task automatic test_deadline_edges();
    // zero period fires on every tick that reaches it
    send_item(CMD_START, 4'd0, 32'd0, TIME_TOP);
    send_item(CMD_TICK, 4'd0, 32'd0, TIME_TOP);
    // deadline wraps past the top of the time range
    send_item(CMD_START, 4'd15, 32'd10, TIME_TOP);
    send_item(CMD_TICK, 4'd0, 32'd0, 48'd8);
    send_item(CMD_TICK, 4'd0, 32'd0, 48'd9);
    // half the time range away counts as not yet reached
    send_item(CMD_TICK, 4'd0, 32'd0, TIME_HALF + 48'd19);
    send_item(CMD_TICK, 4'd0, 32'd0, TIME_HALF + 48'd18);
    settle();
  endtask

  task automatic test_full_scan();
    calm = 1'b1;
    for (int s = 0; s < SLOTS; s++) send_item(CMD_START, ID_W'(s), PERIOD_W'(s * 3), 48'd1000);
    send_item(CMD_TICK, 4'd0, 32'd0, 48'd5000);
    settle();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic(input int count);
    logic [TIME_W-1:0]   clock_ms;
    logic [PERIOD_W-1:0] period;
    int                  pick;
    clock_ms = rand_time();
    for (int i = 0; i < count; i++) begin
      calm = (i >= count * 2 / 5) && (i < count * 3 / 5);
      pick = $urandom_range(99);
      if (pick < 40) begin
        clock_ms = clock_ms + (($urandom_range(19) == 0) ? 48'd2000 : 48'($urandom_range(30)));
        send_item(CMD_TICK, ID_W'($urandom), PERIOD_W'($urandom), clock_ms);
      end else if (pick < 72) begin
        period = ($urandom_range(9) == 0) ? PERIOD_W'($urandom) : PERIOD_W'($urandom_range(50));
        send_item(CMD_START, ID_W'($urandom), period, clock_ms);
      end else if (pick < 88) begin
        send_item(CMD_STOP, ID_W'($urandom), PERIOD_W'($urandom), clock_ms);
      end else begin
        // noise: any command with arbitrary fields
        send_item(CMD_W'($urandom), ID_W'($urandom), PERIOD_W'($urandom), rand_time());
      end
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      timer_running[s] = 1'b0;
      timer_period[s] = '0;
      timer_deadline[s] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quiet_bank();
    test_start_stop();
    test_deadline_edges();
    test_full_scan();
    test_random_traffic(200);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
